// ----- design/tt_pkg.sv -----
// Shared types and constants for the triangle tangent pipeline.
// Used by tt_isqrt_pipe, tt_div_pipe and triangle_tangent_calc; no dependencies.
`default_nettype none
package tt_pkg;

   localparam int NormW   = 30;   // normalized magnitude width, top bit at 29
   localparam int SumW    = 62;   // sum of three squared 30-bit magnitudes
   localparam int SqW     = 63;   // working width of the root recurrence
   localparam int SqSteps = 31;   // one result bit per stage
   localparam int LenW    = 31;   // root width
   localparam int QuoW    = 16;   // quotient bits, at most 2^15
   localparam int RemW    = 32;

   typedef struct packed {
      logic en;    // whole pipeline advances
      logic vld;   // an item enters the first stage
   } pipe_ctl_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } sign_side_type;

   typedef struct packed {
      logic [2:0][NormW-1:0] mag;
      sign_side_type         sgn;
   } mag_side_type;

endpackage
`default_nettype wire

// ----- design/tt_isqrt_pipe.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on tt_pkg.
`default_nettype none
module tt_isqrt_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tt_pkg::pipe_ctl_type ctl,
   input  wire logic [tt_pkg::SumW-1:0] sum,
   input  wire tt_pkg::mag_side_type side_i,
   output logic                      vld_o,
   output logic [tt_pkg::LenW-1:0]   len_o,
   output tt_pkg::mag_side_type      side_o
);
   import tt_pkg::*;

   logic [SqW-1:0] x_ff   [0:SqSteps-1];
   logic [SqW-1:0] res_ff [0:SqSteps-1];
   mag_side_type   side_ff[0:SqSteps-1];
   logic           vld_ff [0:SqSteps-1];
   logic [SqW-1:0] x_in   [0:SqSteps-1];
   logic [SqW-1:0] res_in [0:SqSteps-1];

   // Stage i tries bit 2^(2*(SqSteps-1-i)) against the remainder.
   always_comb begin
      logic [SqW-1:0] xp, rp, bt, trial;
      for (int i = 0; i < SqSteps; i++) begin
         xp = (i == 0) ? SqW'(sum) : x_ff[i-1];
         rp = (i == 0) ? '0 : res_ff[i-1];
         bt = SqW'(1) << (2 * (SqSteps - 1 - i));
         trial = rp + bt;
         if (xp >= trial) begin
            x_in[i]   = xp - trial;
            res_in[i] = (rp >> 1) + bt;
         end else begin
            x_in[i]   = xp;
            res_in[i] = rp >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SqSteps; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (ctl.en) begin
            vld_ff[i] <= (i == 0) ? ctl.vld : vld_ff[i-1];
         end
         if (ctl.en) begin
            x_ff[i]    <= x_in[i];
            res_ff[i]  <= res_in[i];
            side_ff[i] <= (i == 0) ? side_i : side_ff[i-1];
         end
      end
   end

   assign vld_o  = vld_ff[SqSteps-1];
   assign len_o  = res_ff[SqSteps-1][LenW-1:0];
   assign side_o = side_ff[SqSteps-1];

endmodule
`default_nettype wire

// ----- design/tt_div_pipe.sv -----
// Pipelined restoring divider for three lanes: (mag << 15) / len, one bit per stage.
// Depends on tt_pkg.
`default_nettype none
module tt_div_pipe (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tt_pkg::pipe_ctl_type  ctl,
   input  wire logic [tt_pkg::LenW-1:0] len,
   input  wire tt_pkg::mag_side_type  side_i,
   output logic                       vld_o,
   output logic [2:0][tt_pkg::QuoW-1:0] quo_o,
   output tt_pkg::sign_side_type      side_o
);
   import tt_pkg::*;

   logic [2:0][RemW-1:0] rem_ff [0:QuoW-1];
   logic [2:0][QuoW-1:0] quo_ff [0:QuoW-1];
   logic [LenW-1:0]      len_ff [0:QuoW-1];
   sign_side_type        side_ff[0:QuoW-1];
   logic                 vld_ff [0:QuoW-1];
   logic [2:0][RemW-1:0] rem_in [0:QuoW-1];
   logic [2:0][QuoW-1:0] quo_in [0:QuoW-1];

   // The dividend's upper part is mag >> 1; only the first quotient bit
   // brings in a nonzero dividend bit (mag bit 0), the rest shift in zeros.
   always_comb begin
      logic [RemW-1:0] rp;
      logic [QuoW-1:0] qp;
      logic [LenW-1:0] lp;
      logic            nb;
      logic [RemW:0]   r2;
      for (int i = 0; i < QuoW; i++) begin
         for (int k = 0; k < 3; k++) begin
            rp = (i == 0) ? RemW'(side_i.mag[k][NormW-1:1]) : rem_ff[i-1][k];
            qp = (i == 0) ? '0 : quo_ff[i-1][k];
            lp = (i == 0) ? len : len_ff[i-1];
            nb = (i == 0) ? side_i.mag[k][0] : 1'b0;
            r2 = {rp, nb};
            if (r2 >= (RemW+1)'(lp)) begin
               rem_in[i][k] = RemW'(r2 - (RemW+1)'(lp));
               quo_in[i][k] = {qp[QuoW-2:0], 1'b1};
            end else begin
               rem_in[i][k] = RemW'(r2);
               quo_in[i][k] = {qp[QuoW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QuoW; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (ctl.en) begin
            vld_ff[i] <= (i == 0) ? ctl.vld : vld_ff[i-1];
         end
         if (ctl.en) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            len_ff[i]  <= (i == 0) ? len : len_ff[i-1];
            side_ff[i] <= (i == 0) ? side_i.sgn : side_ff[i-1];
         end
      end
   end

   assign vld_o  = vld_ff[QuoW-1];
   assign quo_o  = quo_ff[QuoW-1];
   assign side_o = side_ff[QuoW-1];

endmodule
`default_nettype wire

// ----- design/triangle_tangent_calc.sv -----
// Top level of the per-triangle tangent unit: delta, product, normalize,
// square-root, divide and rounding stages. Depends on tt_pkg, tt_isqrt_pipe, tt_div_pipe.
//
// Usage: one triangle item enters on the req_ stream (three Q11.12 positions and
// three packed Q3.12 UV pairs) and one result item leaves on the rsp_ stream:
// a unit tangent in Q1.14 in rsp_tdata and a degenerate flag in rsp_tuser.
// A degenerate item (zero UV determinant or zero tangent) carries a zero tangent.
// From acceptance to rsp_tvalid an item passes eight front stages
// (deltas, products, differences, sign, leading-one search, shift, squares, sum),
// 31 stages of the square root (one root bit each), 16 stages of the divider
// (one quotient bit each) and the rounding/output register.
// Throughput is one item per cycle; every stage is a register with its own
// valid bit. The whole pipeline advances whenever the output register is
// empty or being taken, so req_tready falls only while a result waits at a
// stalled receiver; nothing is lost or repeated during a stall.
// Reset (synchronous, active high) clears all valid bits; data registers are
// not reset.
`default_nettype none
module triangle_tangent_calc (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos0_x, pos0_y, pos0_z, pos1_x .. pos2_z (24 each), uv0_pair, uv1_pair,
   // uv2_pair (32 each), from bit 0 up
   input  wire logic [311:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tangent_x, tangent_y, tangent_z (16 each), from bit 0 up
   output logic [47:0]       rsp_tdata,
   // degenerate
   output logic [0:0]        rsp_tuser
);
   import tt_pkg::*;

   logic en;
   pipe_ctl_type ctl_sq, ctl_dv;

   // Stage 1: edge and UV deltas.
   logic [8:1] v_ff;   // valid bits of the eight front stages (index 1..8)
   logic signed [16:0] d1u_ff, d1v_ff, d2u_ff, d2v_ff;
   logic signed [2:0][24:0] e1_ff, e2_ff;
   // Stage 2: products.
   logic signed [33:0] pa_ff, pb_ff;
   logic signed [2:0][41:0] ra_ff, rb_ff;
   // Stage 3: determinant and raw direction.
   logic signed [34:0] det_ff;
   logic signed [2:0][42:0] r_ff;
   // Stage 4: magnitudes and signs.
   logic [2:0][41:0] mag_ff, mag5_ff;
   logic [2:0] neg_ff, neg5_ff, neg6_ff, neg7_ff, neg8_ff;
   logic dz_ff, dz5_ff;
   // Stage 5: leading-one position of the largest magnitude.
   logic [5:0] msb_ff;
   logic nz_ff;
   // Stage 6..8: normalized magnitudes, squares, sum.
   logic [2:0][NormW-1:0] nm_ff, nm7_ff, nm8_ff;
   logic dg6_ff, dg7_ff, dg8_ff;
   logic [2:0][59:0] sqr_ff;
   logic [SumW-1:0] sum_ff;

   logic signed [2:0][42:0] rs_in;
   logic [2:0][41:0] mag_in;
   logic [2:0] neg_in;
   logic [41:0] orv_in;
   logic [5:0] msb_in;
   logic [2:0][NormW-1:0] nm_in;

   logic signed [15:0] u0, u1, u2, w0, w1, w2;

   mag_side_type sq_side_i;
   mag_side_type sq_side_o;
   logic sq_vld;
   logic [LenW-1:0] sq_len;
   logic dv_vld;
   logic [2:0][QuoW-1:0] dv_quo;
   sign_side_type dv_side;

   logic out_vld_ff;
   logic [47:0] out_data_ff;
   logic out_dg_ff;
   logic [47:0] out_data_in;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   assign u0 = req_tdata[231:216];
   assign w0 = req_tdata[247:232];
   assign u1 = req_tdata[263:248];
   assign w1 = req_tdata[279:264];
   assign u2 = req_tdata[295:280];
   assign w2 = req_tdata[311:296];

   // Elements of a packed array read back unsigned, so the sign is taken
   // from the top bit and operands are cast to signed before widening.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rs_in[k]  = (det_ff < 0) ? -r_ff[k] : r_ff[k];
         neg_in[k] = rs_in[k][42];
         mag_in[k] = neg_in[k] ? 42'(-rs_in[k]) : 42'(rs_in[k]);
      end
      orv_in = mag_ff[0] | mag_ff[1] | mag_ff[2];
      msb_in = '0;
      for (int b = 0; b < 42; b++) begin
         if (orv_in[b]) msb_in = 6'(b);
      end
      for (int k = 0; k < 3; k++) begin
         if (msb_ff >= 6'd29) begin
            nm_in[k] = NormW'(mag5_ff[k] >> (msb_ff - 6'd29));
         end else begin
            nm_in[k] = NormW'(mag5_ff[k] << (6'd29 - msb_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[7:1], req_tvalid};
      end
      if (en) begin
         d1u_ff <= 17'(u1) - 17'(u0);
         d1v_ff <= 17'(w1) - 17'(w0);
         d2u_ff <= 17'(u2) - 17'(u0);
         d2v_ff <= 17'(w2) - 17'(w0);
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= 25'(signed'(req_tdata[72+24*k +: 24]))
                      - 25'(signed'(req_tdata[24*k +: 24]));
            e2_ff[k] <= 25'(signed'(req_tdata[144+24*k +: 24]))
                      - 25'(signed'(req_tdata[24*k +: 24]));
            ra_ff[k] <= 42'(d2v_ff) * 42'(signed'(e1_ff[k]));
            rb_ff[k] <= 42'(d1v_ff) * 42'(signed'(e2_ff[k]));
            r_ff[k]  <= 43'(signed'(ra_ff[k])) - 43'(signed'(rb_ff[k]));
            sqr_ff[k] <= 60'(nm_ff[k]) * 60'(nm_ff[k]);
         end
         pa_ff  <= 34'(d1u_ff) * 34'(d2v_ff);
         pb_ff  <= 34'(d2u_ff) * 34'(d1v_ff);
         det_ff <= 35'(pa_ff) - 35'(pb_ff);
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         dz_ff  <= det_ff == '0;
         mag5_ff <= mag_ff;
         neg5_ff <= neg_ff;
         dz5_ff  <= dz_ff;
         msb_ff  <= msb_in;
         nz_ff   <= orv_in != '0;
         nm_ff   <= nm_in;
         neg6_ff <= neg5_ff;
         dg6_ff  <= dz5_ff || !nz_ff;
         nm7_ff  <= nm_ff;
         neg7_ff <= neg6_ff;
         dg7_ff  <= dg6_ff;
         nm8_ff  <= nm7_ff;
         neg8_ff <= neg7_ff;
         dg8_ff  <= dg7_ff;
         sum_ff  <= SumW'(sqr_ff[0]) + SumW'(sqr_ff[1]) + SumW'(sqr_ff[2]);
      end
   end

   assign ctl_sq    = '{en: en, vld: v_ff[8]};
   assign sq_side_i = '{mag: nm8_ff, sgn: '{neg: neg8_ff, degen: dg8_ff}};

   tt_isqrt_pipe u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_sq),
      .sum    (sum_ff),
      .side_i (sq_side_i),
      .vld_o  (sq_vld),
      .len_o  (sq_len),
      .side_o (sq_side_o)
   );

   assign ctl_dv = '{en: en, vld: sq_vld};

   tt_div_pipe u_div (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_dv),
      .len    (sq_len),
      .side_i (sq_side_o),
      .vld_o  (dv_vld),
      .quo_o  (dv_quo),
      .side_o (dv_side)
   );

   // Round half up on the magnitude, saturate to 1.0 and apply the sign; a degenerate item gives zero.
   always_comb begin
      logic [QuoW:0] rq;
      logic [15:0]   t;
      for (int k = 0; k < 3; k++) begin
         rq = ((QuoW+1)'(dv_quo[k]) + (QuoW+1)'(1)) >> 1;
         t  = (rq > 17'd16384) ? 16'd16384 : rq[15:0];
         if (dv_side.degen) begin
            out_data_in[16*k +: 16] = '0;
         end else begin
            out_data_in[16*k +: 16] = dv_side.neg[k] ? 16'(-t) : t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_vld;
      end
      if (en) begin
         out_data_ff <= out_data_in;
         out_dg_ff   <= dv_side.degen;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_dg_ff;

endmodule
`default_nettype wire
